// ===== design/afa_pkg.sv =====
// ----------------------------------------------------------------------------
// afa_pkg
// shared types and constants of the approximate float alu
// ----------------------------------------------------------------------------
`default_nettype none

package afa_pkg;

    // operation codes carried on the slave tuser
    typedef enum logic [2:0] {
        OP_MUL  = 3'd0,
        OP_ADD  = 3'd1,
        OP_SUB  = 3'd2,
        OP_LOG2 = 3'd3,
        OP_SQRT = 3'd4,
        OP_INV  = 3'd5
    } op_t;

    // special-operand flags inside the float units
    typedef struct packed {
        logic nan;
        logic inf;
        logic zero;
    } spec_t;

    localparam logic [31:0] QNAN     = 32'h7FC0_0000;
    localparam logic [31:0] SIGN_BIT = 32'h8000_0000;

    // coefficient bit patterns (binary32)
    localparam logic [31:0] C_LOG_SLOPE  = 32'h3F7C_0EBF; // 0.9846
    localparam logic [31:0] C_LOG_OFFS_N = 32'hBF6B_6AE8; // -0.9196
    localparam logic [31:0] C_SQRT_K0    = 32'h4005_1EB8; // 2.08
    localparam logic [31:0] C_SQRT_K1    = 32'h3F98_75F7; // 1.1911
    localparam logic [31:0] C_INV_K0     = 32'h4034_AC08; // 2.823
    localparam logic [31:0] C_INV_K1     = 32'h3FF0_E560; // 1.882

    // depth of each float unit and of the chain of three units
    localparam int UNIT_DEPTH = 3;
    localparam int PIPE_DEPTH = 3 * UNIT_DEPTH;

endpackage

`default_nettype wire

// ===== design/approximate_float_alu.sv =====
// ----------------------------------------------------------------------------
// approximate_float_alu
// pipelined approximate binary32 alu: mul, add, sub, log2, sqrt, inverse
// ----------------------------------------------------------------------------
// The unit takes one transaction per clock while the master side is not
// stalled, and returns exactly one result per transaction, in order. The
// pipeline depth is set by the longest chain of real float work
// (sqrt: multiply, subtract, multiply), built from three float units of three
// register stages each, followed by the output register. Every operation runs
// through the same nine stages, so results never reorder. When the master
// side stalls the whole pipeline holds and the slave side stops accepting;
// nothing is dropped or repeated. Mul is the cheap field-add approximation;
// add and sub pass the larger operand through when the exponents are more
// than eight apart; log2, sqrt and inverse are fixed short polynomials
// evaluated with ieee single precision (round to nearest even, subnormals
// kept). Any nan result is returned as the quiet nan 0x7FC00000, and an
// unknown operation code returns zero.
// ----------------------------------------------------------------------------
`default_nettype none

module approximate_float_alu (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // slave side
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [63:0] s_axis_tdata,  // [31:0] operand_a, [63:32] operand_b
    input  wire logic [2:0]  s_axis_tuser,  // [2:0] req_type
    // master side
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic      [31:0] m_axis_tdata   // [31:0] result_bits
);
    import afa_pkg::*;

    // per-transaction data riding alongside the float units
    typedef struct packed {
        op_t         op;
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] aux;   // field-add product (mul result, or log2 mantissa term)
        logic [31:0] ef;    // log2 integer part as a float
        logic        byp;   // add/sub operands far apart
        logic [31:0] bypv;  // pass-through value for that case
    } side_t;

    // field-add multiply approximation, 32-bit wrap throughout
    function automatic logic [31:0] approx_mul(input logic [31:0] x, input logic [31:0] z);
        logic [31:0] ms;
        logic [31:0] r;
        begin
            ms = {9'd0, x[22:0]} + {9'd0, z[22:0]};
            r  = ms + 32'h0080_0000;
            if (ms[23])
                r = (r >> 1) + 32'h0080_0000;
            r = r + (x & 32'h7F80_0000) + (z & 32'h7F80_0000) - 32'h4000_0000;
            return r | ((x ^ z) & SIGN_BIT);
        end
    endfunction

    // top nine bits as signed, minus 128, as an exact binary32
    function automatic logic [31:0] log2_int(input logic [31:0] x);
        logic signed [9:0] e;
        logic [8:0]        mag;
        logic [3:0]        k;
        logic [31:0]       sh;
        begin
            e   = $signed({x[31], x[31:23]}) - 10'sd128;
            mag = e[9] ? 9'(-e) : e[8:0];
            k   = 4'd0;
            for (int i = 0; i < 9; i++)
            begin
                if (mag[i])
                    k = 4'(i);
            end
            sh = {23'd0, mag} << (5'd23 - {1'b0, k});
            if (mag == 9'd0)
                return 32'd0;
            return {e[9], 8'd127 + {4'd0, k}, sh[22:0]};
        end
    endfunction

    function automatic logic [31:0] canon(input logic [31:0] x);
        begin
            if ((x[30:23] == 8'hFF) && (x[22:0] != 23'd0))
                return QNAN;
            return x;
        end
    endfunction

    // pipeline advance: everything moves unless the output is full and stalled
    logic adv;
    logic out_valid_reg;
    logic [31:0] out_data_reg, out_data_next;

    assign adv           = m_axis_tready | ~out_valid_reg;
    assign s_axis_tready = adv;

    // input decode
    op_t         in_op;
    logic [31:0] in_a, in_b;
    logic signed [8:0] ediff;
    side_t       in_side;

    assign in_op = op_t'(s_axis_tuser);
    assign in_a  = s_axis_tdata[31:0];
    assign in_b  = s_axis_tdata[63:32];
    assign ediff = $signed({1'b0, in_a[30:23]}) - $signed({1'b0, in_b[30:23]});

    always_comb
    begin
        in_side.op   = in_op;
        in_side.a    = in_a;
        in_side.b    = in_b;
        in_side.aux  = approx_mul(in_a, (in_op == OP_LOG2) ? C_LOG_SLOPE : in_b);
        in_side.ef   = log2_int(in_a);
        in_side.byp  = (ediff > 9'sd8) || (ediff < -9'sd8);
        if (ediff > 9'sd8)
            in_side.bypv = in_a;
        else if (in_op == OP_SUB)
            in_side.bypv = in_b ^ SIGN_BIT;
        else
            in_side.bypv = in_b;
    end

    // side pipeline, stage k is aligned with k+1 register levels of the units
    logic  valid_reg [PIPE_DEPTH];
    side_t side_reg  [PIPE_DEPTH];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < PIPE_DEPTH; i++)
                valid_reg[i] <= 1'b0;
        end
        else if (adv)
        begin
            valid_reg[0] <= s_axis_tvalid;
            for (int i = 1; i < PIPE_DEPTH; i++)
                valid_reg[i] <= valid_reg[i-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            side_reg[0] <= in_side;
            for (int i = 1; i < PIPE_DEPTH; i++)
                side_reg[i] <= side_reg[i-1];
        end
    end

    // first multiply: coefficient times x for sqrt and inverse
    logic [31:0] m1_y;

    afa_fp_mul u_mul1 (
        .clk (clk),
        .en  (adv),
        .a   (in_a),
        .b   ((in_op == OP_SQRT) ? C_SQRT_K1 : C_INV_K1),
        .y   (m1_y)
    );

    // first add: a +/- b, log2 int + mantissa term, k0 - product
    localparam int S1 = UNIT_DEPTH - 1;
    localparam int S2 = 2 * UNIT_DEPTH - 1;
    localparam int S3 = PIPE_DEPTH - 1;

    logic [31:0] a1_a, a1_b, a1_y;

    always_comb
    begin
        case (side_reg[S1].op)
            OP_ADD:
            begin
                a1_a = side_reg[S1].a;
                a1_b = side_reg[S1].b;
            end
            OP_SUB:
            begin
                a1_a = side_reg[S1].a;
                a1_b = side_reg[S1].b ^ SIGN_BIT;
            end
            OP_LOG2:
            begin
                a1_a = side_reg[S1].ef;
                a1_b = side_reg[S1].aux;
            end
            OP_SQRT:
            begin
                a1_a = C_SQRT_K0;
                a1_b = m1_y ^ SIGN_BIT;
            end
            OP_INV:
            begin
                a1_a = C_INV_K0;
                a1_b = m1_y ^ SIGN_BIT;
            end
            default:
            begin
                a1_a = side_reg[S1].a;
                a1_b = side_reg[S1].b;
            end
        endcase
    end

    afa_fp_add u_add1 (
        .clk (clk),
        .en  (adv),
        .a   (a1_a),
        .b   (a1_b),
        .y   (a1_y)
    );

    // second add for log2 offset, second multiply for sqrt
    logic [31:0] a2_y, m2_y;

    afa_fp_add u_add2 (
        .clk (clk),
        .en  (adv),
        .a   (a1_y),
        .b   (C_LOG_OFFS_N),
        .y   (a2_y)
    );

    afa_fp_mul u_mul2 (
        .clk (clk),
        .en  (adv),
        .a   (side_reg[S2].a),
        .b   (a1_y),
        .y   (m2_y)
    );

    // first-add result delayed to line up with the last stage
    logic [31:0] r1_reg [UNIT_DEPTH];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            r1_reg[0] <= a1_y;
            for (int i = 1; i < UNIT_DEPTH; i++)
                r1_reg[i] <= r1_reg[i-1];
        end
    end

    // result select
    always_comb
    begin
        case (side_reg[S3].op)
            OP_MUL:  out_data_next = side_reg[S3].aux;
            OP_ADD,
            OP_SUB:  out_data_next = side_reg[S3].byp ? side_reg[S3].bypv
                                                      : r1_reg[UNIT_DEPTH-1];
            OP_LOG2: out_data_next = a2_y;
            OP_SQRT: out_data_next = m2_y;
            OP_INV:  out_data_next = r1_reg[UNIT_DEPTH-1];
            default: out_data_next = 32'd0;
        endcase
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (adv)
            out_valid_reg <= valid_reg[S3];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            out_data_reg <= canon(out_data_next);
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

endmodule

`default_nettype wire

// ===== design/afa_fp_mul.sv =====
// ----------------------------------------------------------------------------
// afa_fp_mul
// three-stage binary32 multiplier, round to nearest even, subnormals kept
// ----------------------------------------------------------------------------
`default_nettype none

module afa_fp_mul (
    input  wire logic        clk,
    input  wire logic        en,
    input  wire logic [31:0] a,
    input  wire logic [31:0] b,
    output logic      [31:0] y
);
    import afa_pkg::*;

    // stage 1: unpack and multiply significands
    logic [7:0]         ea, eb, eea, eeb;
    logic [23:0]        ma, mb;
    spec_t              sp;
    logic               a_nan, b_nan, a_inf, b_inf, a_zero, b_zero;

    logic [47:0]        s1_prod_reg;
    logic signed [10:0] s1_exp_reg;
    logic               s1_sign_reg;
    spec_t              s1_spec_reg;

    assign ea     = a[30:23];
    assign eb     = b[30:23];
    assign eea    = (ea == 8'd0) ? 8'd1 : ea;
    assign eeb    = (eb == 8'd0) ? 8'd1 : eb;
    assign ma     = {ea != 8'd0, a[22:0]};
    assign mb     = {eb != 8'd0, b[22:0]};
    assign a_nan  = (ea == 8'hFF) && (a[22:0] != 23'd0);
    assign b_nan  = (eb == 8'hFF) && (b[22:0] != 23'd0);
    assign a_inf  = (ea == 8'hFF) && (a[22:0] == 23'd0);
    assign b_inf  = (eb == 8'hFF) && (b[22:0] == 23'd0);
    assign a_zero = (a[30:0] == 31'd0);
    assign b_zero = (b[30:0] == 31'd0);
    assign sp.nan  = a_nan | b_nan | (a_inf & b_zero) | (b_inf & a_zero);
    assign sp.inf  = a_inf | b_inf;
    assign sp.zero = a_zero | b_zero;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_prod_reg <= ma * mb;
            s1_exp_reg  <= $signed({3'b0, eea}) + $signed({3'b0, eeb}) - 11'sd127;
            s1_sign_reg <= a[31] ^ b[31];
            s1_spec_reg <= sp;
        end
    end

    // stage 2: leading-zero count and shift amount
    logic [5:0]         lz;
    logic signed [10:0] expn, sl;

    logic [47:0]        s2_prod_reg;
    logic signed [10:0] s2_exp_reg;
    logic signed [10:0] s2_sl_reg;
    logic               s2_sign_reg;
    spec_t              s2_spec_reg;

    always_comb
    begin
        lz = 6'd0;
        for (int i = 0; i < 48; i++)
        begin
            if (s1_prod_reg[i])
                lz = 6'(47 - i);
        end
    end

    assign expn = s1_exp_reg + 11'sd1 - $signed({5'b0, lz});
    assign sl   = (expn >= 11'sd1) ? $signed({5'b0, lz})
                                   : $signed({5'b0, lz}) + expn - 11'sd1;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s2_prod_reg <= s1_prod_reg;
            s2_exp_reg  <= expn;
            s2_sl_reg   <= sl;
            s2_sign_reg <= s1_sign_reg;
            s2_spec_reg <= s1_spec_reg;
        end
    end

    // stage 3: normalize or denormalize, round, pack
    logic [47:0]        v;
    logic               sticky;
    logic [95:0]        w;
    logic signed [10:0] rs;
    logic [5:0]         rsc;
    logic [7:0]         exp_field;
    logic               rnd;
    logic [30:0]        packed_mag;
    logic [31:0]        y_next;
    logic [31:0]        y_reg;

    assign rs  = -s2_sl_reg;
    assign rsc = (rs > 11'sd63) ? 6'd63 : rs[5:0];
    assign w   = {s2_prod_reg, 48'd0} >> rsc;

    always_comb
    begin
        if (!s2_sl_reg[10])
        begin
            v      = s2_prod_reg << s2_sl_reg[5:0];
            sticky = 1'b0;
        end
        else
        begin
            v      = w[95:48];
            sticky = |w[47:0];
        end
    end

    assign exp_field  = (s2_exp_reg >= 11'sd1) ? s2_exp_reg[7:0] : 8'd0;
    assign rnd        = v[23] & ((|v[22:0]) | sticky | v[24]);
    assign packed_mag = {exp_field, v[46:24]} + {30'd0, rnd};

    always_comb
    begin
        if (s2_spec_reg.nan)
            y_next = QNAN;
        else if (s2_spec_reg.inf || (s2_exp_reg >= 11'sd255))
            y_next = {s2_sign_reg, 8'hFF, 23'd0};
        else if (s2_spec_reg.zero)
            y_next = {s2_sign_reg, 31'd0};
        else
            y_next = {s2_sign_reg, packed_mag};
    end

    always_ff @(posedge clk)
    begin
        if (en)
            y_reg <= y_next;
    end

    assign y = y_reg;

endmodule

`default_nettype wire

// ===== design/afa_fp_add.sv =====
// ----------------------------------------------------------------------------
// afa_fp_add
// three-stage binary32 adder, round to nearest even, subnormals kept
// ----------------------------------------------------------------------------
`default_nettype none

module afa_fp_add (
    input  wire logic        clk,
    input  wire logic        en,
    input  wire logic [31:0] a,
    input  wire logic [31:0] b,
    output logic      [31:0] y
);
    import afa_pkg::*;

    // stage 1: specials, order by magnitude, exponent difference
    logic        swap;
    logic [31:0] lg, sm;
    logic [7:0]  el, es, eel, ees;
    logic        a_nan, b_nan, a_inf, b_inf;
    spec_t       sp;

    logic [7:0]  s1_el_reg;
    logic [23:0] s1_ml_reg;
    logic [23:0] s1_ms_reg;
    logic [7:0]  s1_d_reg;
    logic        s1_sl_reg;
    logic        s1_sub_reg;
    logic        s1_isign_reg;
    spec_t       s1_spec_reg;

    assign a_nan = (a[30:23] == 8'hFF) && (a[22:0] != 23'd0);
    assign b_nan = (b[30:23] == 8'hFF) && (b[22:0] != 23'd0);
    assign a_inf = (a[30:23] == 8'hFF) && (a[22:0] == 23'd0);
    assign b_inf = (b[30:23] == 8'hFF) && (b[22:0] == 23'd0);
    assign sp.nan  = a_nan | b_nan | (a_inf & b_inf & (a[31] ^ b[31]));
    assign sp.inf  = a_inf | b_inf;
    assign sp.zero = 1'b0;

    assign swap = (b[30:0] > a[30:0]);
    assign lg   = swap ? b : a;
    assign sm   = swap ? a : b;
    assign el   = lg[30:23];
    assign es   = sm[30:23];
    assign eel  = (el == 8'd0) ? 8'd1 : el;
    assign ees  = (es == 8'd0) ? 8'd1 : es;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_el_reg    <= eel;
            s1_ml_reg    <= {el != 8'd0, lg[22:0]};
            s1_ms_reg    <= {es != 8'd0, sm[22:0]};
            s1_d_reg     <= eel - ees;
            s1_sl_reg    <= lg[31];
            s1_sub_reg   <= a[31] ^ b[31];
            s1_isign_reg <= a_inf ? a[31] : b[31];
            s1_spec_reg  <= sp;
        end
    end

    // stage 2: align the smaller operand, add or subtract
    logic [4:0]  dc;
    logic [58:0] w;
    logic [27:0] lop, sop;

    logic [27:0] s2_r_reg;
    logic [7:0]  s2_el_reg;
    logic        s2_sl_reg;
    logic        s2_sub_reg;
    logic        s2_isign_reg;
    spec_t       s2_spec_reg;

    assign dc  = (s1_d_reg > 8'd31) ? 5'd31 : s1_d_reg[4:0];
    assign w   = {s1_ms_reg, 3'b000, 32'd0} >> dc;
    assign lop = {1'b0, s1_ml_reg, 3'b000};
    assign sop = {1'b0, w[58:33], w[32] | (|w[31:0])};

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s2_r_reg     <= s1_sub_reg ? (lop - sop) : (lop + sop);
            s2_el_reg    <= s1_el_reg;
            s2_sl_reg    <= s1_sl_reg;
            s2_sub_reg   <= s1_sub_reg;
            s2_isign_reg <= s1_isign_reg;
            s2_spec_reg  <= s1_spec_reg;
        end
    end

    // stage 3: normalize, round, pack
    logic [4:0]  lz, sh;
    logic [7:0]  lim;
    logic [26:0] nrm;
    logic [8:0]  ex;
    logic [7:0]  exp_field;
    logic        rnd;
    logic [30:0] packed_mag;
    logic [31:0] y_next;
    logic [31:0] y_reg;

    always_comb
    begin
        lz = 5'd0;
        for (int i = 0; i < 27; i++)
        begin
            if (s2_r_reg[i])
                lz = 5'(26 - i);
        end
    end

    assign lim = s2_el_reg - 8'd1;
    assign sh  = ({3'b0, lz} > lim) ? lim[4:0] : lz;

    always_comb
    begin
        if (s2_r_reg[27])
        begin
            nrm = {s2_r_reg[27:2], s2_r_reg[1] | s2_r_reg[0]};
            ex  = {1'b0, s2_el_reg} + 9'd1;
        end
        else
        begin
            nrm = s2_r_reg[26:0] << sh;
            ex  = {1'b0, s2_el_reg} - {4'b0, sh};
        end
    end

    assign exp_field  = nrm[26] ? ex[7:0] : 8'd0;
    assign rnd        = nrm[2] & (nrm[1] | nrm[0] | nrm[3]);
    assign packed_mag = {exp_field, nrm[25:3]} + {30'd0, rnd};

    always_comb
    begin
        if (s2_spec_reg.nan)
            y_next = QNAN;
        else if (s2_spec_reg.inf)
            y_next = {s2_isign_reg, 8'hFF, 23'd0};
        else if (s2_r_reg == 28'd0)
            y_next = {s2_sub_reg ? 1'b0 : s2_sl_reg, 31'd0};
        else if (ex >= 9'd255)
            y_next = {s2_sl_reg, 8'hFF, 23'd0};
        else
            y_next = {s2_sl_reg, packed_mag};
    end

    always_ff @(posedge clk)
    begin
        if (en)
            y_reg <= y_next;
    end

    assign y = y_reg;

endmodule

`default_nettype wire
